// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the endpoint transfer sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition never true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== hdl/uets_pkg.sv =====
// ----------------------------------------------------------------------------
// uets_pkg
// Types, codes and sizes shared by the endpoint transfer sequencer.
// ----------------------------------------------------------------------------
package uets_pkg;

   localparam int NUM_ENDPOINTS    = 16;
   localparam int MAX_PACKET_BYTES = 1023;
   localparam int LEN_W            = 16;
   localparam int EP_IDX_W         = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
   localparam int E_W              = EP_IDX_W + 1;
   localparam int NUM_E            = 2 * NUM_ENDPOINTS;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [1:0] {
      OP_OPEN   = 2'd0,
      OP_START  = 2'd1,
      OP_REPORT = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CLS_OPEN,
      CLS_REJECT,
      CLS_START,
      CLS_REPORT
   } cls_type;

   typedef enum logic [2:0] {
      ACT_OPEN_OK  = 3'd0,
      ACT_SEND_IN  = 3'd1,
      ACT_ARM_OUT  = 3'd2,
      ACT_COPY_OUT = 3'd3,
      ACT_COMPLETE = 3'd4,
      ACT_REJECT   = 3'd5
   } action_type;

   localparam logic [1:0] KIND_BULK    = 2'd1;
   localparam logic [1:0] KIND_CONTROL = 2'd3;

   localparam logic [1:0] DS_UNUSED = 2'd0;
   localparam logic [1:0] DS_ARMED  = 2'd1;
   localparam logic [1:0] DS_OK     = 2'd2;
   localparam logic [1:0] DS_ERR    = 2'd3;

   typedef struct packed {
      cls_type          cls;
      logic [3:0]       ep;
      logic             dir;
      logic [1:0]       kind;
      logic [9:0]       mps;
      logic [LEN_W-1:0] tlen;
      logic             slot;
      logic             ok;
      logic [10:0]      rb;
   } item_type;

   typedef struct packed {
      action_type       action;
      logic [3:0]       ep;
      logic             dir;
      logic             slot;
      logic [15:0]      addr;
      logic [15:0]      off;
      logic [15:0]      cnt;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic                   busy;
      logic                   dbl;
      logic                   fs;
      logic                   rs;
      logic [9:0]             mps;
      logic [LEN_W-1:0]       tot;
      logic [LEN_W-1:0]       done;
      logic [1:0][1:0]        st;
      logic [1:0][15:0]       addr;
      logic [1:0][15:0]       len;
   } ctx_type;

   typedef struct packed {
      logic idle;
      logic hold_valid;
      logic pop;
   } back_status_type;

endpackage

// ===== hdl/uets_front.sv =====
// ----------------------------------------------------------------------------
// uets_front
// Accepts request transfers, classifies them and queues those it keeps for the back end.
// ----------------------------------------------------------------------------
module uets_front
   import uets_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_ep_number,
   input  logic        req_direction,
   input  logic [1:0]  req_ep_kind,
   input  logic [9:0]  req_max_packet,
   input  logic [15:0] req_transfer_length,
   input  logic        req_desc_slot,
   input  logic        req_packet_ok,
   input  logic [10:0] req_received_bytes,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   mem_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   it;
   logic       keep, push;
   logic       ep_ok;

   assign req_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = mem_ff[rp_ff];

   always_comb begin
      ep_ok   = (32'(req_ep_number) < NUM_ENDPOINTS);
      it.ep   = req_ep_number;
      it.dir  = req_direction;
      it.kind = req_ep_kind;
      it.mps  = req_max_packet;
      it.tlen = req_transfer_length;
      it.slot = req_desc_slot;
      it.ok   = req_packet_ok;
      it.rb   = req_received_bytes;
      it.cls  = CLS_START;
      keep    = 1'b0;
      case (opcode_type'(req_opcode))
         OP_OPEN: begin
            keep   = 1'b1;
            it.cls = (req_ep_kind == KIND_CONTROL || !ep_ok) ? CLS_REJECT : CLS_OPEN;
         end
         OP_START: begin
            keep   = ep_ok;
            it.cls = CLS_START;
         end
         OP_REPORT: begin
            keep   = ep_ok;
            it.cls = CLS_REPORT;
         end
         default: keep = 1'b0;
      endcase
      push   = req_valid && req_ready && keep;
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= it;
      end
   end

endmodule

// ===== hdl/uets_back.sv =====
// ----------------------------------------------------------------------------
// uets_back
// Endpoint tables and the sequencer that retires and fills descriptors.
// ----------------------------------------------------------------------------
module uets_back
   import uets_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  item_type        q_item,
   output logic            q_pop,
   output rsp_type         rsp,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output back_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPEN,
      ST_RET,
      ST_FILL,
      ST_CMPL,
      ST_DONE
   } state_type;

   ctx_type          tab_ff [NUM_E];
   logic [15:0]      alloc_ff [2];
   state_type        state_ff, state_in, ret_ff, ret_in;
   logic [1:0]       step_ff, step_in, rstep_ff, rstep_in;
   ctx_type          w_ff, w_in;
   logic [E_W-1:0]   e_ff, e_in, qe;
   logic [3:0]       ep_ff, ep_in;
   logic             dir_ff, dir_in;
   logic [LEN_W-1:0] cval_ff, cval_in;
   rsp_type          hold_ff, hold_in, rsp_ff, out_r;
   logic             hv_ff, hv_in, rv_ff;
   logic             out_free, go, emit, push, wb, alloc_we, last_push;
   rsp_type          er;
   ctx_type          c;
   logic [9:0]       mpc;
   logic [15:0]      a1, alloc_new;
   logic             s;
   logic [LEN_W-1:0] rem, plen, nd;
   state_type        nx_state;
   logic [1:0]       nx_step;

   function automatic rsp_type mk(action_type a, logic [3:0] ep, logic dir, logic sl,
                                  logic [15:0] ad, logic [15:0] of, logic [15:0] cn);
      rsp_type r;
      r.action = a;
      r.ep     = ep;
      r.dir    = dir;
      r.slot   = sl;
      r.addr   = ad;
      r.off    = of;
      r.cnt    = cn;
      r.last   = 1'b0;
      return r;
   endfunction

   assign out_free  = !rv_ff || rsp_ready;
   assign go        = !hv_ff || out_free;
   assign rsp       = rsp_ff;
   assign rsp_valid = rv_ff;
   assign qe        = {q_item.ep[EP_IDX_W-1:0], q_item.dir};
   assign status    = '{idle: (state_ff == ST_IDLE), hold_valid: hv_ff, pop: q_pop};

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      ret_in    = ret_ff;
      rstep_in  = rstep_ff;
      w_in      = w_ff;
      e_in      = e_ff;
      ep_in     = ep_ff;
      dir_in    = dir_ff;
      cval_in   = cval_ff;
      hold_in   = hold_ff;
      hv_in     = hv_ff;
      emit      = 1'b0;
      er        = hold_ff;
      q_pop     = 1'b0;
      wb        = 1'b0;
      alloc_we  = 1'b0;
      last_push = 1'b0;
      c         = tab_ff[qe];
      mpc       = (11'(q_item.mps) > 11'(MAX_PACKET_BYTES)) ? 10'(MAX_PACKET_BYTES)
                                                            : q_item.mps;
      a1        = alloc_ff[q_item.dir] + 16'(mpc);
      alloc_new = (q_item.kind == KIND_BULK) ? a1 + 16'(mpc) : a1;
      s         = 1'b0;
      rem       = w_ff.tot - w_ff.done;
      plen      = '0;
      nd        = '0;
      nx_state  = ST_DONE;
      nx_step   = 2'd0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               e_in   = qe;
               ep_in  = q_item.ep;
               dir_in = q_item.dir;
               step_in = 2'd0;
               case (q_item.cls)
                  CLS_OPEN: begin
                     c.busy    = 1'b0;
                     c.dbl     = (q_item.kind == KIND_BULK);
                     c.fs      = 1'b0;
                     c.rs      = 1'b0;
                     c.mps     = mpc;
                     c.tot     = '0;
                     c.done    = '0;
                     c.st      = '0;
                     c.len     = '0;
                     c.addr[0] = alloc_ff[q_item.dir];
                     c.addr[1] = (q_item.kind == KIND_BULK) ? a1 : 16'd0;
                     alloc_we  = 1'b1;
                     state_in  = ST_OPEN;
                  end
                  CLS_REJECT: begin
                     emit     = 1'b1;
                     er       = mk(ACT_REJECT, q_item.ep, q_item.dir, 1'b0, 16'd0, 16'd0,
                                   16'd0);
                     state_in = ST_DONE;
                  end
                  CLS_START: begin
                     c.busy   = 1'b1;
                     c.tot    = q_item.tlen;
                     c.done   = '0;
                     state_in = ST_RET;
                  end
                  default: begin
                     if (c.st[q_item.slot] == DS_ARMED) begin
                        c.st[q_item.slot]  = q_item.ok ? DS_OK : DS_ERR;
                        c.len[q_item.slot] = 16'(q_item.rb);
                     end
                     state_in = ST_RET;
                  end
               endcase
               w_in = c;
            end
         end
         ST_OPEN: begin
            if (go) begin
               case (step_ff)
                  2'd0: begin
                     emit     = 1'b1;
                     er       = mk(ACT_OPEN_OK, ep_ff, dir_ff, 1'b0, w_ff.addr[0], 16'd0,
                                   16'(w_ff.mps));
                     state_in = dir_ff ? ST_DONE : ST_OPEN;
                     step_in  = 2'd1;
                  end
                  2'd1: begin
                     w_in.st[0]  = DS_ARMED;
                     w_in.len[0] = 16'(w_ff.mps);
                     emit        = 1'b1;
                     er          = mk(ACT_ARM_OUT, ep_ff, 1'b0, 1'b0, w_ff.addr[0], 16'd0,
                                      16'(w_ff.mps));
                     state_in    = w_ff.dbl ? ST_OPEN : ST_DONE;
                     step_in     = 2'd2;
                  end
                  default: begin
                     w_in.st[1]  = DS_ARMED;
                     w_in.len[1] = 16'(w_ff.mps);
                     emit        = 1'b1;
                     er          = mk(ACT_ARM_OUT, ep_ff, 1'b0, 1'b1, w_ff.addr[1], 16'd0,
                                      16'(w_ff.mps));
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end
         ST_RET: begin
            s = w_ff.rs;
            if (step_ff[0]) begin
               nx_state = ST_FILL;
               nx_step  = 2'd0;
            end else begin
               nx_state = ST_RET;
               nx_step  = 2'd1;
            end
            if (go) begin
               if (dir_ff) begin
                  if (w_ff.st[s] == DS_UNUSED || w_ff.st[s] == DS_ARMED) begin
                     state_in = ST_FILL;
                     step_in  = 2'd0;
                  end else begin
                     w_in.st[s] = DS_UNUSED;
                     w_in.rs    = w_ff.rs ^ w_ff.dbl;
                     state_in   = nx_state;
                     step_in    = nx_step;
                  end
               end else if (w_ff.st[s] == DS_OK) begin
                  if (!w_ff.busy) begin
                     state_in = ST_FILL;
                     step_in  = 2'd0;
                  end else begin
                     plen = (w_ff.len[s] >= 16'd2) ? w_ff.len[s] - 16'd2 : '0;
                     if (plen > rem) begin
                        plen = rem;
                     end
                     nd         = w_ff.done + plen;
                     w_in.st[s] = DS_UNUSED;
                     w_in.rs    = w_ff.rs ^ w_ff.dbl;
                     w_in.done  = nd;
                     state_in   = nx_state;
                     step_in    = nx_step;
                     if (plen != '0) begin
                        emit = 1'b1;
                        er   = mk(ACT_COPY_OUT, ep_ff, 1'b0, s, w_ff.addr[s], w_ff.done,
                                  plen);
                     end
                     if (plen < LEN_W'(w_ff.mps) || nd == w_ff.tot) begin
                        w_in.busy = 1'b0;
                        w_in.tot  = '0;
                        w_in.done = '0;
                        if (plen != '0) begin
                           cval_in  = nd;
                           ret_in   = nx_state;
                           rstep_in = nx_step;
                           state_in = ST_CMPL;
                        end else begin
                           emit = 1'b1;
                           er   = mk(ACT_COMPLETE, ep_ff, 1'b0, 1'b0, 16'd0, 16'd0, nd);
                        end
                     end
                  end
               end else if (w_ff.st[s] == DS_ERR) begin
                  w_in.st[s]  = DS_ARMED;
                  w_in.len[s] = 16'(w_ff.mps);
                  w_in.rs     = w_ff.rs ^ w_ff.dbl;
                  emit        = 1'b1;
                  er          = mk(ACT_ARM_OUT, ep_ff, 1'b0, s, w_ff.addr[s], 16'd0,
                                   16'(w_ff.mps));
                  state_in    = nx_state;
                  step_in     = nx_step;
               end else begin
                  state_in = ST_FILL;
                  step_in  = 2'd0;
               end
            end
         end
         ST_FILL: begin
            s = w_ff.fs;
            if (step_ff[0]) begin
               nx_state = ST_DONE;
            end else begin
               nx_state = ST_FILL;
               nx_step  = 2'd1;
            end
            if (go) begin
               if (w_ff.st[s] != DS_UNUSED || (dir_ff && !w_ff.busy)) begin
                  state_in = ST_DONE;
               end else if (!dir_ff) begin
                  w_in.st[s]  = DS_ARMED;
                  w_in.len[s] = 16'(w_ff.mps);
                  w_in.fs     = w_ff.fs ^ w_ff.dbl;
                  emit        = 1'b1;
                  er          = mk(ACT_ARM_OUT, ep_ff, 1'b0, s, w_ff.addr[s], 16'd0,
                                   16'(w_ff.mps));
                  state_in    = nx_state;
                  step_in     = nx_step;
               end else begin
                  plen        = (rem > LEN_W'(w_ff.mps)) ? LEN_W'(w_ff.mps) : rem;
                  nd          = w_ff.done + plen;
                  w_in.st[s]  = DS_ARMED;
                  w_in.len[s] = plen;
                  w_in.fs     = w_ff.fs ^ w_ff.dbl;
                  emit        = 1'b1;
                  er          = mk(ACT_SEND_IN, ep_ff, 1'b1, s, w_ff.addr[s], w_ff.done, plen);
                  state_in    = nx_state;
                  step_in     = nx_step;
                  w_in.done   = nd;
                  if (nd == w_ff.tot) begin
                     cval_in   = w_ff.tot;
                     w_in.busy = 1'b0;
                     w_in.tot  = '0;
                     w_in.done = '0;
                     ret_in    = nx_state;
                     rstep_in  = nx_step;
                     state_in  = ST_CMPL;
                  end
               end
            end
         end
         ST_CMPL: begin
            if (go) begin
               emit     = 1'b1;
               er       = mk(ACT_COMPLETE, ep_ff, dir_ff, 1'b0, 16'd0, 16'd0, cval_ff);
               state_in = ret_ff;
               step_in  = rstep_ff;
            end
         end
         default: begin
            if (go) begin
               wb        = 1'b1;
               last_push = hv_ff;
               hv_in     = 1'b0;
               state_in  = ST_IDLE;
            end
         end
      endcase
      push = (emit && hv_ff) || last_push;
      if (emit) begin
         hold_in = er;
         hv_in   = 1'b1;
      end
      out_r      = hold_ff;
      out_r.last = last_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
         ret_ff   <= ST_DONE;
         rstep_ff <= 2'd0;
         hv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
         alloc_ff[0] <= 16'd0;
         alloc_ff[1] <= 16'd0;
         for (int i = 0; i < NUM_E; i++) begin
            tab_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ret_ff   <= ret_in;
         rstep_ff <= rstep_in;
         hv_ff    <= hv_in;
         if (push) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
         if (alloc_we) begin
            alloc_ff[q_item.dir] <= alloc_new;
         end
         if (wb) begin
            tab_ff[e_ff] <= w_ff;
         end
      end
      w_ff    <= w_in;
      e_ff    <= e_in;
      ep_ff   <= ep_in;
      dir_ff  <= dir_in;
      cval_ff <= cval_in;
      hold_ff <= hold_in;
      if (push) begin
         rsp_ff <= out_r;
      end
   end

endmodule

// ===== hdl/usb_endpoint_transfer_sequencer.sv =====
// A queued item enters the sequencer when the sequencer is idle and pops the queue; each
// result passes through a hold register to the output register. The sequencer takes one
// item at a time, works through it one descriptor step at a time and waits while the result
// side stalls. A two-entry queue takes new items while the sequencer works.
// Reset clears all endpoint tables, allocators and the queue.
// ----------------------------------------------------------------------------
// usb_endpoint_transfer_sequencer
// Per-endpoint USB transfer sequencer with ping-pong buffer descriptors.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module usb_endpoint_transfer_sequencer
   import uets_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_ep_number,
   input  logic        req_direction,
   input  logic [1:0]  req_ep_kind,
   input  logic [9:0]  req_max_packet,
   input  logic [15:0] req_transfer_length,
   input  logic        req_desc_slot,
   input  logic        req_packet_ok,
   input  logic [10:0] req_received_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [3:0]  rsp_res_ep,
   output logic        rsp_res_dir,
   output logic        rsp_res_slot,
   output logic [15:0] rsp_buffer_address,
   output logic [15:0] rsp_data_offset,
   output logic [15:0] rsp_byte_count,
   output logic        rsp_last
);

   logic            q_valid, q_pop;
   item_type        q_item;
   rsp_type         rsp;
   back_status_type bstat;

   uets_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_ep_number       (req_ep_number),
      .req_direction       (req_direction),
      .req_ep_kind         (req_ep_kind),
      .req_max_packet      (req_max_packet),
      .req_transfer_length (req_transfer_length),
      .req_desc_slot       (req_desc_slot),
      .req_packet_ok       (req_packet_ok),
      .req_received_bytes  (req_received_bytes),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop)
   );

   uets_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (bstat)
   );

   assign rsp_action         = rsp.action;
   assign rsp_res_ep         = rsp.ep;
   assign rsp_res_dir        = rsp.dir;
   assign rsp_res_slot       = rsp.slot;
   assign rsp_buffer_address = rsp.addr;
   assign rsp_data_offset    = rsp.off;
   assign rsp_byte_count     = rsp.cnt;
   assign rsp_last           = rsp.last;

   `ASSERT_IMPLY(a_pop_needs_item, clock, reset, bstat.pop, q_valid, "pop from empty queue")
   `ASSERT_IMPLY(a_pop_only_idle, clock, reset, bstat.pop, bstat.idle, "pop while busy")
   `ASSERT_NEVER(a_idle_no_hold, clock, reset, bstat.idle && bstat.hold_valid, "result held")
   `ASSERT_IMPLY(a_last_then_idle, clock, reset, rsp_valid && rsp_ready && rsp_last && !bstat.idle, $past(bstat.idle) == 1'b0 || bstat.pop == 1'b0, "last result out of order")

endmodule

// ===== dv/tb_usb_endpoint_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_usb_endpoint_transfer_sequencer
// Sends endpoint opens, transfer starts and packet reports to the sequencer.
// A local model of the endpoint and descriptor tables predicts every action,
// and each action that comes out is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_usb_endpoint_transfer_sequencer;
   import uets_pkg::*;

   typedef struct {
      logic [2:0]  action;
      logic [3:0]  ep;
      logic        dir;
      logic        slot;
      logic [15:0] addr;
      logic [15:0] off;
      logic [15:0] cnt;
      logic        last;
   } exp_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_ep_number = '0;
   logic        req_direction = 1'b0;
   logic [1:0]  req_ep_kind = '0;
   logic [9:0]  req_max_packet = '0;
   logic [15:0] req_transfer_length = '0;
   logic        req_desc_slot = 1'b0;
   logic        req_packet_ok = 1'b0;
   logic [10:0] req_received_bytes = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_action;
   logic [3:0]  rsp_res_ep;
   logic        rsp_res_dir;
   logic        rsp_res_slot;
   logic [15:0] rsp_buffer_address;
   logic [15:0] rsp_data_offset;
   logic [15:0] rsp_byte_count;
   logic        rsp_last;

   // endpoint and descriptor tables of the prediction
   logic        m_busy [32];
   logic        m_dbl [32];
   logic        m_fill [32];
   logic        m_retire [32];
   logic [9:0]  m_mps [32];
   logic [15:0] m_total [32];
   logic [15:0] m_done [32];
   logic [1:0]  m_st [64];
   logic [15:0] m_addr [64];
   logic [15:0] m_len [64];
   logic [15:0] m_alloc [2];
   logic        m_opened [32];

   exp_type     pending_actions[$];
   exp_type     step_out[$];
   int          errors = 0;
   int          items_sent = 0;
   int          actions_seen = 0;
   int          idle_in_pct = 0;
   int          stall_out_pct = 0;
   int          quiet_cycles = 0;

   usb_endpoint_transfer_sequencer DUT (.*);

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic void push_action(input action_type a, input int ep, input logic dir,
                                       input logic slot, input logic [15:0] addr,
                                       input logic [15:0] off, input logic [15:0] cnt);
      exp_type r;
      r.action = a; r.ep = ep[3:0]; r.dir = dir; r.slot = slot;
      r.addr = addr; r.off = off; r.cnt = cnt; r.last = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void advance_in_ep(input int ep);
      int e, d;
      logic [15:0] rem, plen;
      logic [15:0] mps;
      e = ep * 2 + 1;
      mps = 16'(m_mps[e]);
      for (int i = 0; i < 2; i++) begin
         d = e * 2 + m_retire[e];
         if (m_st[d] < DS_OK) break;
         m_st[d] = DS_UNUSED;
         m_retire[e] ^= m_dbl[e];
      end
      for (int i = 0; i < 2 && m_busy[e]; i++) begin
         d = e * 2 + m_fill[e];
         if (m_st[d] != DS_UNUSED) break;
         rem = m_total[e] - m_done[e];
         plen = (rem > mps) ? mps : rem;
         m_st[d] = DS_ARMED;
         m_len[d] = plen;
         push_action(ACT_SEND_IN, ep, 1'b1, m_fill[e], m_addr[d], m_done[e], plen);
         m_done[e] = m_done[e] + plen;
         if (m_done[e] == m_total[e]) begin
            push_action(ACT_COMPLETE, ep, 1'b1, 1'b0, 16'd0, 16'd0, m_total[e]);
            m_busy[e] = 1'b0;
            m_total[e] = '0;
            m_done[e] = '0;
         end
         m_fill[e] ^= m_dbl[e];
      end
   endfunction

   function automatic void advance_out_ep(input int ep);
      int e, d;
      logic [15:0] rem, plen, mps;
      logic slot;
      e = ep * 2;
      mps = 16'(m_mps[e]);
      for (int i = 0; i < 2; i++) begin
         slot = m_retire[e];
         d = e * 2 + slot;
         if (m_st[d] == DS_OK) begin
            if (!m_busy[e]) break;
            plen = (m_len[d] >= 2) ? m_len[d] - 16'd2 : 16'd0;
            rem = m_total[e] - m_done[e];
            if (plen > rem) plen = rem;
            m_st[d] = DS_UNUSED;
            if (plen != 0) begin
               push_action(ACT_COPY_OUT, ep, 1'b0, slot, m_addr[d], m_done[e], plen);
               m_done[e] = m_done[e] + plen;
            end
            if (plen < mps || m_done[e] == m_total[e]) begin
               push_action(ACT_COMPLETE, ep, 1'b0, 1'b0, 16'd0, 16'd0, m_done[e]);
               m_busy[e] = 1'b0;
               m_total[e] = '0;
               m_done[e] = '0;
            end
         end else if (m_st[d] == DS_ERR) begin
            m_st[d] = DS_ARMED;
            m_len[d] = mps;
            push_action(ACT_ARM_OUT, ep, 1'b0, slot, m_addr[d], 16'd0, mps);
         end else begin
            break;
         end
         m_retire[e] ^= m_dbl[e];
      end
      for (int i = 0; i < 2; i++) begin
         slot = m_fill[e];
         d = e * 2 + slot;
         if (m_st[d] != DS_UNUSED) break;
         m_st[d] = DS_ARMED;
         m_len[d] = mps;
         push_action(ACT_ARM_OUT, ep, 1'b0, slot, m_addr[d], 16'd0, mps);
         m_fill[e] ^= m_dbl[e];
      end
   endfunction

   function automatic void open_endpoint(input int ep, input logic dir,
                                         input logic [1:0] kind, input logic [9:0] mp);
      int e, d;
      logic [15:0] mps;
      e = ep * 2 + dir;
      d = e * 2;
      mps = (mp > MAX_PACKET_BYTES) ? 16'(MAX_PACKET_BYTES) : 16'(mp);
      if (kind == KIND_CONTROL || ep >= NUM_ENDPOINTS) begin
         push_action(ACT_REJECT, ep, dir, 1'b0, 16'd0, 16'd0, 16'd0);
         return;
      end
      m_opened[e] = 1'b1;
      m_busy[e] = 1'b0;
      m_dbl[e] = (kind == KIND_BULK);
      m_fill[e] = 1'b0;
      m_retire[e] = 1'b0;
      m_mps[e] = mps[9:0];
      m_total[e] = '0;
      m_done[e] = '0;
      m_addr[d] = m_alloc[dir];
      m_alloc[dir] = m_alloc[dir] + mps;
      if (m_dbl[e]) begin
         m_addr[d+1] = m_alloc[dir];
         m_alloc[dir] = m_alloc[dir] + mps;
      end else begin
         m_addr[d+1] = '0;
      end
      m_st[d] = DS_UNUSED; m_st[d+1] = DS_UNUSED;
      m_len[d] = '0; m_len[d+1] = '0;
      push_action(ACT_OPEN_OK, ep, dir, 1'b0, m_addr[d], 16'd0, mps);
      if (!dir) begin
         m_st[d] = DS_ARMED;
         m_len[d] = mps;
         push_action(ACT_ARM_OUT, ep, 1'b0, 1'b0, m_addr[d], 16'd0, mps);
         if (m_dbl[e]) begin
            m_st[d+1] = DS_ARMED;
            m_len[d+1] = mps;
            push_action(ACT_ARM_OUT, ep, 1'b0, 1'b1, m_addr[d+1], 16'd0, mps);
         end
      end
   endfunction

   // predict the actions of one accepted item and queue them
   function automatic void predict_actions(input logic [1:0] op, input int ep, input logic dir,
                                           input logic [1:0] kind, input logic [9:0] mp,
                                           input logic [15:0] tlen, input logic slot,
                                           input logic ok, input logic [10:0] rb);
      int e, d;
      e = ep * 2 + dir;
      step_out.delete();
      if (op == OP_OPEN) begin
         open_endpoint(ep, dir, kind, mp);
      end else if ((op == OP_START || op == OP_REPORT) && ep < NUM_ENDPOINTS) begin
         if (op == OP_START) begin
            m_busy[e] = 1'b1;
            m_total[e] = tlen;
            m_done[e] = '0;
         end else begin
            d = e * 2 + slot;
            if (m_st[d] == DS_ARMED) begin
               m_st[d] = ok ? DS_OK : DS_ERR;
               m_len[d] = 16'(rb);
            end
         end
         if (dir) advance_in_ep(ep);
         else advance_out_ep(ep);
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) pending_actions.push_back(step_out[i]);
   endfunction

   task automatic send_item(input logic [1:0] op, input int ep, input logic dir,
                            input logic [1:0] kind, input logic [9:0] mp,
                            input logic [15:0] tlen, input logic slot,
                            input logic ok, input logic [10:0] rb);
      while ($urandom_range(99) < idle_in_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_ep_number <= ep[3:0];
      req_direction <= dir;
      req_ep_kind <= kind;
      req_max_packet <= mp;
      req_transfer_length <= tlen;
      req_desc_slot <= slot;
      req_packet_ok <= ok;
      req_received_bytes <= rb;
      do @(posedge clock); while (!req_ready);
      predict_actions(op, ep, dir, kind, mp, tlen, slot, ok, rb);
      items_sent++;
   endtask

   task automatic drain_actions();
      req_valid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // check every accepted action
   always @(posedge clock) begin
      exp_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         actions_seen++;
         if (pending_actions.size() == 0) begin
            report_mismatch($sformatf("unexpected action %0d ep %0d", rsp_action, rsp_res_ep));
         end else begin
            x = pending_actions.pop_front();
            if (rsp_action !== x.action || rsp_res_ep !== x.ep || rsp_res_dir !== x.dir ||
                rsp_res_slot !== x.slot || rsp_buffer_address !== x.addr ||
                rsp_data_offset !== x.off || rsp_byte_count !== x.cnt ||
                rsp_last !== x.last)
               report_mismatch($sformatf(
                  "got a%0d e%0d d%0d s%0d @%0h o%0d n%0d l%0d, want a%0d e%0d d%0d s%0d @%0h o%0d n%0d l%0d",
                  rsp_action, rsp_res_ep, rsp_res_dir, rsp_res_slot, rsp_buffer_address,
                  rsp_data_offset, rsp_byte_count, rsp_last, x.action, x.ep, x.dir, x.slot,
                  x.addr, x.off, x.cnt, x.last));
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_out_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d actions outstanding", pending_actions.size());
         $display("usb_endpoint_transfer_sequencer test failed");
         $finish;
      end
   end

   task automatic test_opens();
      // control kind rejected and the largest packet size, 1023, taken as it is
      send_item(OP_OPEN, 1, 1'b1, KIND_CONTROL, 10'd64, 16'd0, 1'b0, 1'b0, 11'd0);
      send_item(OP_OPEN, 1, 1'b1, KIND_BULK, 10'd1023, 16'd0, 1'b0, 1'b0, 11'd0);
      send_item(OP_OPEN, 1, 1'b0, KIND_BULK, 10'd8, 16'd0, 1'b0, 1'b0, 11'd0);
      send_item(OP_OPEN, 2, 1'b1, 2'd0, 10'd0, 16'd0, 1'b0, 1'b0, 11'd0);
      send_item(OP_OPEN, 3, 1'b0, 2'd2, 10'd16, 16'd0, 1'b0, 1'b0, 11'd0);
      send_item(OP_OPEN, 15, 1'b1, 2'd2, 10'd512, 16'd0, 1'b0, 1'b0, 11'd0);
      send_item(OP_NONE, 15, 1'b1, KIND_CONTROL, 10'h3ff, 16'hffff, 1'b1, 1'b1, 11'h7ff);
   endtask

   task automatic test_in_transfers();
      send_item(OP_START, 1, 1'b1, 2'd0, 10'd0, 16'd0, 1'b0, 1'b0, 11'd0);
      send_item(OP_REPORT, 1, 1'b1, 2'd0, 10'd0, 16'd0, 1'b0, 1'b1, 11'd0);
      send_item(OP_START, 1, 1'b1, 2'd0, 10'd0, 16'd2100, 1'b0, 1'b0, 11'd0);
      send_item(OP_REPORT, 1, 1'b1, 2'd0, 10'd0, 16'd0, 1'b1, 1'b0, 11'd0);
      send_item(OP_REPORT, 1, 1'b1, 2'd0, 10'd0, 16'd0, 1'b0, 1'b1, 11'd0);
      send_item(OP_REPORT, 1, 1'b1, 2'd0, 10'd0, 16'd0, 1'b1, 1'b1, 11'd0);
      send_item(OP_START, 2, 1'b1, 2'd0, 10'd0, 16'd5, 1'b0, 1'b0, 11'd0);
      send_item(OP_START, 15, 1'b1, 2'd0, 10'd0, 16'hffff, 1'b0, 1'b0, 11'd0);
      send_item(OP_START, 15, 1'b1, 2'd0, 10'd0, 16'd3, 1'b0, 1'b0, 11'd0);
   endtask

   task automatic test_out_transfers();
      send_item(OP_REPORT, 1, 1'b0, 2'd0, 10'd0, 16'd0, 1'b0, 1'b1, 11'd10);
      send_item(OP_START, 1, 1'b0, 2'd0, 10'd0, 16'd20, 1'b0, 1'b0, 11'd0);
      send_item(OP_REPORT, 1, 1'b0, 2'd0, 10'd0, 16'd0, 1'b1, 1'b0, 11'd10);
      send_item(OP_REPORT, 1, 1'b0, 2'd0, 10'd0, 16'd0, 1'b1, 1'b1, 11'd1);
      send_item(OP_START, 3, 1'b0, 2'd0, 10'd0, 16'd4, 1'b0, 1'b0, 11'd0);
      send_item(OP_REPORT, 3, 1'b0, 2'd0, 10'd0, 16'd0, 1'b0, 1'b1, 11'd1025);
      send_item(OP_START, 1, 1'b0, 2'd0, 10'd0, 16'd0, 1'b0, 1'b0, 11'd0);
   endtask

   task automatic test_random(input int count);
      int ep, kind, op;
      logic dir;
      for (int n = 0; n < count; n++) begin
         ep = $urandom_range(15);
         dir = 1'($urandom_range(1));
         op = $urandom_range(99);
         if (!m_opened[ep*2+dir] || op < 8) begin
            kind = $urandom_range(3);
            send_item(OP_OPEN, ep, dir, kind[1:0],
                      ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(64, 1)),
                      16'd0, 1'b0, 1'b0, 11'd0);
         end else if (op < 30) begin
            send_item(OP_START, ep, dir, 2'($urandom), 10'($urandom),
                      ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(200)),
                      1'($urandom), 1'($urandom), 11'($urandom));
         end else if (op < 33) begin
            send_item(OP_NONE, ep, dir, 2'($urandom), 10'($urandom), 16'($urandom),
                      1'($urandom), 1'($urandom), 11'($urandom));
         end else begin
            send_item(OP_REPORT, ep, dir, 2'($urandom), 10'($urandom), 16'($urandom),
                      ($urandom_range(3) == 0) ? 1'($urandom) : m_retire[ep*2+dir],
                      ($urandom_range(7) != 0),
                      ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(66)));
         end
      end
   endtask

   initial begin
      foreach (m_busy[i]) begin
         m_busy[i] = 0; m_dbl[i] = 0; m_fill[i] = 0; m_retire[i] = 0;
         m_mps[i] = 0; m_total[i] = 0; m_done[i] = 0; m_opened[i] = 0;
      end
      foreach (m_st[i]) begin
         m_st[i] = DS_UNUSED; m_addr[i] = 0; m_len[i] = 0;
      end
      m_alloc[0] = 0; m_alloc[1] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_opens();
      test_in_transfers();
      test_out_transfers();
      drain_actions();
      test_random(70);
      idle_in_pct = 74;
      test_random(70);
      drain_actions();
      idle_in_pct = 0;
      stall_out_pct = 74;
      test_random(70);
      idle_in_pct = 28;
      stall_out_pct = 28;
      test_random(70);
      idle_in_pct = 0;
      stall_out_pct = 0;
      drain_actions();
      $display("covered %0d items (opens, IN and OUT transfers, good and bad reports)",
               items_sent);
      $display("checked %0d actions across four idle and stall mixes", actions_seen);
      if (errors == 0 && pending_actions.size() == 0)
         $display("usb_endpoint_transfer_sequencer test passed");
      else
         $display("usb_endpoint_transfer_sequencer test failed");
      $finish;
   end

endmodule
